// File: src/tpt_pkg.sv
// Shared types and constants for the touch point table.
package tpt_pkg;

   localparam int unsigned FINGER_BITS = 32;
   localparam int unsigned TIME_BITS = 32;
   localparam int unsigned FIELD_COORD_BITS = 16;
   localparam int unsigned COORD_BITS = FIELD_COORD_BITS;

   localparam logic [1:0] KIND_DOWN   = 2'd0;
   localparam logic [1:0] KIND_MOTION = 2'd1;
   localparam logic [1:0] KIND_UP     = 2'd2;
   localparam logic [1:0] KIND_QUERY  = 2'd3;

   typedef struct packed {
      logic [1:0]                    kind;
      logic [FINGER_BITS-1:0]        finger;
      logic [FIELD_COORD_BITS-1:0]   pos_x;
      logic [FIELD_COORD_BITS-1:0]   pos_y;
      logic [FIELD_COORD_BITS-1:0]   radius;
      logic signed [TIME_BITS-1:0]   time_ms;
   } req_type;

   typedef struct packed {
      logic                          hit;
      logic [FINGER_BITS-1:0]        hit_finger;
      logic [FIELD_COORD_BITS-1:0]   hit_x;
      logic [FIELD_COORD_BITS-1:0]   hit_y;
      logic signed [TIME_BITS-1:0]   hit_time;
      logic                          hit_fresh;
      logic                          overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_SQUARE,
      ST_SUM,
      ST_FETCH,
      ST_DONE
   } state_type;

endpackage

// File: src/tpt_front.sv
// Input stage and two-entry queue that decouples accept from execution.
module tpt_front
   import tpt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    q_valid,
   input  logic    q_take,
   output req_type q_data
);

   req_type    slot_ff [2];
   req_type    slot_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req_stall = cnt_ff == 2'd2;
   assign push = req_valid && !req_stall;
   assign q_valid = cnt_ff != 2'd0;
   assign q_data = slot_ff[0];

   always_comb begin
      slot_in = slot_ff;
      cnt_in = cnt_ff;
      if (q_take && q_valid) begin
         slot_in[0] = slot_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         slot_in[cnt_in[0]] = req_data;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: src/tpt_back.sv
// Table storage and sequencer that walks entries for each operation.
module tpt_back
   import tpt_pkg::*;
#(
   parameter int unsigned MAX_TOUCHES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   output logic    q_take,
   input  req_type q_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned IW = (MAX_TOUCHES > 1) ? $clog2(MAX_TOUCHES) : 1;
   localparam int unsigned CW = $clog2(MAX_TOUCHES + 1);
   localparam int unsigned SW = 2 * COORD_BITS;
   localparam int unsigned DW = SW + 1;
   localparam logic [CW-1:0] FULL = CW'(MAX_TOUCHES);

   typedef struct packed {
      logic [FINGER_BITS-1:0]      finger;
      logic [COORD_BITS-1:0]       x;
      logic [COORD_BITS-1:0]       y;
      logic signed [TIME_BITS-1:0] tm;
      logic                        fresh;
   } entry_type;

   entry_type     mem [MAX_TOUCHES];
   entry_type     rd_ff;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;
   logic [IW-1:0] rd_addr;

   state_type     st_ff, st_in;
   req_type       op_ff, op_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ri_ff, ri_in;
   logic [CW-1:0] wi_ff, wi_in;
   logic          found_ff, found_in;
   logic          hit_ff, hit_in;
   logic [IW-1:0] best_ff, best_in;
   logic [DW-1:0] bestd_ff, bestd_in;
   logic [SW-1:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic          ok_ff, ok_in;
   logic          ovf_ff, ovf_in;
   logic          out_v_ff, out_v_in;
   rsp_type       out_ff, out_in;
   logic [COORD_BITS-1:0] ax, ay, dx, dy, rad;

   assign ax = op_ff.pos_x[COORD_BITS-1:0];
   assign ay = op_ff.pos_y[COORD_BITS-1:0];
   assign rad = op_ff.radius[COORD_BITS-1:0];
   assign dx = (rd_ff.x >= ax) ? rd_ff.x - ax : ax - rd_ff.x;
   assign dy = (rd_ff.y >= ay) ? rd_ff.y - ay : ay - rd_ff.y;
   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      st_in = st_ff;
      op_in = op_ff;
      count_in = count_ff;
      ri_in = ri_ff;
      wi_in = wi_ff;
      found_in = found_ff;
      hit_in = hit_ff;
      best_in = best_ff;
      bestd_in = bestd_ff;
      sqx_in = sqx_ff;
      sqy_in = sqy_ff;
      ok_in = ok_ff;
      ovf_in = ovf_ff;
      out_v_in = out_v_ff;
      out_in = out_ff;
      q_take = 1'b0;
      wr_en = 1'b0;
      wr_addr = count_ff[IW-1:0];
      wr_data = '0;
      rd_addr = ri_ff[IW-1:0];
      if (out_v_ff && !rsp_stall) begin
         out_v_in = 1'b0;
      end
      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_take = 1'b1;
               op_in = q_data;
               ri_in = '0;
               wi_in = '0;
               found_in = 1'b0;
               hit_in = 1'b0;
               ovf_in = 1'b0;
               best_in = '0;
               bestd_in = DW'(rad) * 0;
               st_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (ri_ff == '0) begin
               bestd_in = DW'({{COORD_BITS{1'b0}}, rad} * {{COORD_BITS{1'b0}}, rad});
            end
            if (op_ff.kind == KIND_DOWN || ri_ff >= count_ff || found_ff) begin
               st_in = ST_FETCH;
               if (op_ff.kind == KIND_UP) begin
                  count_in = wi_ff;
               end else if ((op_ff.kind == KIND_DOWN || op_ff.kind == KIND_MOTION)
                            && !found_ff) begin
                  if (count_ff == FULL) begin
                     ovf_in = 1'b1;
                  end else begin
                     wr_en = 1'b1;
                     wr_data.finger = op_ff.finger;
                     wr_data.x = ax;
                     wr_data.y = ay;
                     wr_data.tm = op_ff.time_ms;
                     wr_data.fresh = op_ff.kind == KIND_DOWN;
                     count_in = count_ff + 1'b1;
                  end
               end
               rd_addr = best_ff;
               if (op_ff.kind == KIND_QUERY && rad == '0) begin
                  hit_in = 1'b0;
               end
            end else begin
               st_in = ST_READ;
            end
         end
         ST_READ: begin
            ok_in = rd_ff.tm <= op_ff.time_ms;
            ri_in = ri_ff + 1'b1;
            st_in = ST_SCAN;
            if (op_ff.kind == KIND_MOTION) begin
               if (rd_ff.finger == op_ff.finger) begin
                  found_in = 1'b1;
                  wr_en = 1'b1;
                  wr_addr = ri_ff[IW-1:0];
                  wr_data.finger = rd_ff.finger;
                  wr_data.x = ax;
                  wr_data.y = ay;
                  wr_data.tm = op_ff.time_ms;
                  wr_data.fresh = 1'b0;
               end
            end else if (op_ff.kind == KIND_UP) begin
               if (rd_ff.finger != op_ff.finger) begin
                  wr_en = 1'b1;
                  wr_addr = wi_ff[IW-1:0];
                  wr_data = rd_ff;
                  wi_in = wi_ff + 1'b1;
               end
            end else begin
               sqx_in = {{COORD_BITS{1'b0}}, dx} * {{COORD_BITS{1'b0}}, dx};
               sqy_in = {{COORD_BITS{1'b0}}, dy} * {{COORD_BITS{1'b0}}, dy};
               ri_in = ri_ff;
               st_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            st_in = ST_SUM;
            if (ok_ff && rad != '0
                && ({1'b0, sqx_ff} + {1'b0, sqy_ff}) < bestd_ff) begin
               bestd_in = {1'b0, sqx_ff} + {1'b0, sqy_ff};
               best_in = ri_ff[IW-1:0];
               hit_in = 1'b1;
            end
         end
         ST_SUM: begin
            ri_in = ri_ff + 1'b1;
            st_in = ST_SCAN;
            rd_addr = ri_in[IW-1:0];
         end
         ST_FETCH: begin
            rd_addr = best_ff;
            st_in = ST_DONE;
         end
         ST_DONE: begin
            rd_addr = best_ff;
            if (!out_v_in) begin
               out_v_in = 1'b1;
               out_in = '0;
               out_in.overflow = ovf_ff;
               if (hit_ff) begin
                  out_in.hit = 1'b1;
                  out_in.hit_finger = rd_ff.finger;
                  out_in.hit_x = FIELD_COORD_BITS'(rd_ff.x);
                  out_in.hit_y = FIELD_COORD_BITS'(rd_ff.y);
                  out_in.hit_time = rd_ff.tm;
                  out_in.hit_fresh = rd_ff.fresh;
               end
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
      if (st_ff == ST_SCAN && st_in == ST_READ) begin
         rd_addr = ri_ff[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      ri_ff <= ri_in;
      wi_ff <= wi_in;
      found_ff <= found_in;
      hit_ff <= hit_in;
      best_ff <= best_in;
      bestd_ff <= bestd_in;
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      ok_ff <= ok_in;
      ovf_ff <= ovf_in;
      out_ff <= out_in;
      if (reset) begin
         st_ff <= ST_IDLE;
         count_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         count_ff <= count_in;
         out_v_ff <= out_v_in;
      end
   end

endmodule

// File: src/touch_point_table_core.sv
// Top level of the touch point table: front queue and table sequencer.
// Sequencer work per item, N stored entries: a down writes its entry without a scan, an up
// walks all N entries, a query scores each entry, and a motion stops at its first match.
// The sequencer handles one item at a time, limited by the single table read port and the
// shared distance unit; a stalled result holds it.
// Reset: synchronous, active high; clears the entry count, queue and output.
module touch_point_table_core
   import tpt_pkg::*;
#(
   parameter int unsigned MAX_TOUCHES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    q_valid, q_take;
   req_type q_data;

   tpt_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_take, .q_data
   );

   tpt_back #(.MAX_TOUCHES(MAX_TOUCHES)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

// File: tb/tb_touch_point_table_core.sv
// Self-checking testbench for the touch point table core: directed and random transfers.
module tb_touch_point_table_core;
   import tpt_pkg::*;

   localparam int unsigned TABLE_DEPTH = 16;
   localparam int unsigned STALL_LIMIT = 20000;

   typedef struct packed {
      logic [31:0]        finger;
      logic [15:0]        x;
      logic [15:0]        y;
      logic signed [31:0] stamp;
      logic               fresh;
   } point_type;

   typedef struct {
      req_type req;
      logic    typed;
      rsp_type rsp;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   point_type table_points[TABLE_DEPTH];
   int unsigned point_count;
   rsp_type expected_rsps[$];
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;
   logic quiet_phase = 1'b0;
   stim_row_type directed_rows[$];

   touch_point_table_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   function automatic logic table_append(input point_type p);
      if (point_count >= TABLE_DEPTH) return 1'b0;
      table_points[point_count] = p;
      point_count++;
      return 1'b1;
   endfunction

   function automatic rsp_type apply_touch(input req_type r);
      rsp_type res;
      point_type p;
      logic found;
      int unsigned keep;
      logic [33:0] best, dx, dy, sq_dist;
      int unsigned best_idx;
      res = '0;
      p.finger = r.finger; p.x = r.pos_x; p.y = r.pos_y; p.stamp = r.time_ms;
      case (r.kind)
         KIND_DOWN: begin
            p.fresh = 1'b1;
            res.overflow = !table_append(p);
         end
         KIND_MOTION: begin
            found = 1'b0;
            for (int i = 0; i < point_count; i++) begin
               if (!found && table_points[i].finger == r.finger) begin
                  p.fresh = 1'b0;
                  table_points[i] = p;
                  found = 1'b1;
               end
            end
            if (!found) begin
               p.fresh = 1'b0;
               res.overflow = !table_append(p);
            end
         end
         KIND_UP: begin
            keep = 0;
            for (int i = 0; i < point_count; i++) begin
               if (table_points[i].finger != r.finger) begin
                  table_points[keep] = table_points[i];
                  keep++;
               end
            end
            point_count = keep;
         end
         default: begin
            if (r.radius != 0) begin
               best = 34'(r.radius) * 34'(r.radius);
               best_idx = 0;
               for (int i = 0; i < point_count; i++) begin
                  if (table_points[i].stamp <= r.time_ms) begin
                     dx = (table_points[i].x >= r.pos_x) ? 34'(table_points[i].x - r.pos_x)
                                                         : 34'(r.pos_x - table_points[i].x);
                     dy = (table_points[i].y >= r.pos_y) ? 34'(table_points[i].y - r.pos_y)
                                                         : 34'(r.pos_y - table_points[i].y);
                     sq_dist = dx * dx + dy * dy;
                     if (sq_dist < best) begin
                        best = sq_dist;
                        best_idx = i;
                        res.hit = 1'b1;
                     end
                  end
               end
               if (res.hit) begin
                  res.hit_finger = table_points[best_idx].finger;
                  res.hit_x = table_points[best_idx].x;
                  res.hit_y = table_points[best_idx].y;
                  res.hit_time = table_points[best_idx].stamp;
                  res.hit_fresh = table_points[best_idx].fresh;
               end
            end
         end
      endcase
      return res;
   endfunction

   function automatic req_type make_req(input logic [1:0] kind, input logic [31:0] finger,
                                        input logic [15:0] x, input logic [15:0] y,
                                        input logic [15:0] radius, input logic [31:0] stamp);
      req_type r;
      r.kind = kind; r.finger = finger; r.pos_x = x; r.pos_y = y;
      r.radius = radius; r.time_ms = stamp;
      return r;
   endfunction

   function automatic rsp_type make_hit(input logic [31:0] finger, input logic [15:0] x,
                                        input logic [15:0] y, input logic [31:0] stamp,
                                        input logic fresh);
      rsp_type s;
      s = '0;
      s.hit = 1'b1; s.hit_finger = finger; s.hit_x = x; s.hit_y = y;
      s.hit_time = stamp; s.hit_fresh = fresh;
      return s;
   endfunction

   function automatic rsp_type ovf_rsp();
      rsp_type s;
      s = '0;
      s.overflow = 1'b1;
      return s;
   endfunction

   function automatic void add_row(input req_type r, input logic typed, input rsp_type s);
      stim_row_type row;
      row.req = r; row.typed = typed; row.rsp = s;
      directed_rows = {directed_rows, row};
   endfunction

   task automatic send_touch(input req_type r, input logic typed, input rsp_type s);
      rsp_type predicted;
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predicted = apply_touch(r);
      if (typed && predicted != s)
         report_mismatch("directed row vs predictor", 64'(predicted), 64'(s));
      expected_rsps = {expected_rsps, predicted};
   endtask

   function automatic req_type random_touch(input int unsigned finger_pool);
      req_type r;
      logic [31:0] f;
      f = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, finger_pool));
      case ($urandom_range(0, 9))
         0, 1, 2: r.kind = KIND_DOWN;
         3, 4:    r.kind = KIND_MOTION;
         5, 6:    r.kind = KIND_UP;
         default: r.kind = KIND_QUERY;
      endcase
      r.finger = f;
      r.pos_x = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 1) * 16'hffff)
                                            : 16'($urandom);
      r.pos_y = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 1) * 16'hffff)
                                            : 16'($urandom);
      case ($urandom_range(0, 5))
         0:       r.radius = 16'hffff;
         1:       r.radius = 16'($urandom_range(0, 3));
         default: r.radius = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0:       r.time_ms = $urandom;
         1:       r.time_ms = ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
         default: r.time_ms = 32'($urandom_range(0, 2000)) - 32'd1000;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset || quiet_phase) begin
         rsp_stall <= 1'b0;
      end else if (rsp_stall) begin
         if ($urandom_range(0, 3) == 0) rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected transfer", 64'(rsp_data.hit), 64'd0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.hit !== want.hit)
               report_mismatch("hit", 64'(rsp_data.hit), 64'(want.hit));
            if (rsp_data.hit_finger !== want.hit_finger)
               report_mismatch("hit_finger", 64'(rsp_data.hit_finger), 64'(want.hit_finger));
            if (rsp_data.hit_x !== want.hit_x)
               report_mismatch("hit_x", 64'(rsp_data.hit_x), 64'(want.hit_x));
            if (rsp_data.hit_y !== want.hit_y)
               report_mismatch("hit_y", 64'(rsp_data.hit_y), 64'(want.hit_y));
            if (rsp_data.hit_time !== want.hit_time)
               report_mismatch("hit_time", 64'(rsp_data.hit_time), 64'(want.hit_time));
            if (rsp_data.hit_fresh !== want.hit_fresh)
               report_mismatch("hit_fresh", 64'(rsp_data.hit_fresh), 64'(want.hit_fresh));
            if (rsp_data.overflow !== want.overflow)
               report_mismatch("overflow", 64'(rsp_data.overflow), 64'(want.overflow));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("touch_point_table_core verification failed");
            $finish;
         end
      end
   end

   initial begin
      rsp_type none;
      none = '0;
      point_count = 0;
      add_row(make_req(KIND_QUERY, 32'h0, 16'h8000, 16'h8000, 16'hffff, 32'h7fffffff), 1, none);
      add_row(make_req(KIND_DOWN, 32'hffffffff, 16'hffff, 16'hffff, 16'h0, 32'h7fffffff),
              1, none);
      add_row(make_req(KIND_QUERY, 32'h0, 16'hffff, 16'hffff, 16'h1, 32'h7fffffff), 1,
              make_hit(32'hffffffff, 16'hffff, 16'hffff, 32'h7fffffff, 1'b1));
      add_row(make_req(KIND_QUERY, 32'h0, 16'hffff, 16'hffff, 16'h0, 32'h7fffffff), 1, none);
      add_row(make_req(KIND_QUERY, 32'h0, 16'hffff, 16'hffff, 16'h5, 32'h7ffffffe), 1, none);
      add_row(make_req(KIND_DOWN, 32'h0, 16'h0, 16'h0, 16'hffff, 32'h80000000), 1, none);
      add_row(make_req(KIND_DOWN, 32'h0, 16'h10, 16'h0, 16'h0, 32'h5), 1, none);
      add_row(make_req(KIND_QUERY, 32'h0, 16'h0, 16'h0, 16'hffff, 32'h80000000), 1,
              make_hit(32'h0, 16'h0, 16'h0, 32'h80000000, 1'b1));
      add_row(make_req(KIND_MOTION, 32'h0, 16'h20, 16'h30, 16'h0, 32'h6), 1, none);
      add_row(make_req(KIND_MOTION, 32'h7, 16'h20, 16'h30, 16'h0, 32'h6), 1, none);
      add_row(make_req(KIND_QUERY, 32'h0, 16'h20, 16'h30, 16'h4, 32'h6), 1,
              make_hit(32'h0, 16'h20, 16'h30, 32'h6, 1'b0));
      add_row(make_req(KIND_UP, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0), 1, none);
      add_row(make_req(KIND_UP, 32'h1234, 16'h0, 16'h0, 16'h0, 32'h0), 1, none);
      add_row(make_req(KIND_QUERY, 32'h0, 16'h10, 16'h0, 16'h1, 32'h7fffffff), 0, none);
      for (int i = 0; i < 14; i++)
         add_row(make_req(KIND_DOWN, 32'(i + 1), 16'(i * 100), 16'(i * 50), 16'h0, 32'(i)),
                 0, none);
      add_row(make_req(KIND_DOWN, 32'h55, 16'h0, 16'h0, 16'h0, 32'h0), 1, ovf_rsp());

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i])
         send_touch(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      for (int n = 0; n < 1521; n++) begin
         if (n == 1350) quiet_phase <= 1'b1;
         send_touch(random_touch((n / 300) % 2 ? 24 : 6), 1'b0, none);
      end
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("touch_point_table_core verification clean");
      end else begin
         $display("touch_point_table_core verification failed");
      end
      $finish;
   end

endmodule
